// ===== sv/bnd_pkg.sv =====
package bnd_pkg;

    // One input beat: state vector and synaptic drive
    typedef struct packed {
        logic signed [31:0] membrane_voltage;
        logic        [16:0] k_gate;
        logic        [16:0] slow_k_gate;
        logic signed [31:0] synaptic_current;
    } t_in_item;

    // One result beat: the three time derivatives
    typedef struct packed {
        logic signed [31:0] voltage_rate;
        logic signed [31:0] k_gate_rate;
        logic signed [31:0] slow_k_gate_rate;
    } t_out_item;

    // Flags and finished gate rates that ride alongside the divider
    typedef struct packed {
        logic               neg;
        logic               zero;
        logic               sat;
        logic signed [31:0] k_rate;
        logic signed [31:0] s_rate;
    } t_div_side;

    localparam int CFG_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 32;

    // Unsigned 64-bit quotient by shift and subtract; only used while building tables
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        logic [64:0]     rem;
        longint unsigned q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Logistic 1/(1+exp(-a)) in Q16.16 for a >= 0 (a in Q16.16).
    // exp(-a/8) by a 14-term series in Q2.30, then squared three times.
    function automatic logic [16:0] logistic_pos(input longint unsigned a);
        longint unsigned y;
        longint unsigned term;
        longint unsigned e;
        longint unsigned den;
        longint unsigned q;
        longint          sum;
        y    = a << 11;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int k = 1; k <= 14; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 << 30)) begin
            sum = 64'sd1 << 30;
        end
        e = longint'(sum);
        for (int k = 0; k < 3; k++) begin
            e = (e * e) >> 30;
        end
        den = (64'd1 << 30) + e;
        q   = udiv64((64'd1 << 46) + (den >> 1), den);
        return q[16:0];
    endfunction

endpackage

// ===== sv/bnd_chan_if.sv =====
interface bnd_chan_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bursting_neuron_derivative.sv =====
// Derivative unit of a three-variable bursting neuron. Each input beat carries the
// membrane voltage, the fast and slow potassium gates and the synaptic current; each
// output beat carries the voltage, fast gate and slow gate rates in signed Q16.16,
// saturated. The datapath is a straight pipeline: one beat is taken every
// cycle while the skid entry is empty. Most of the pipeline is the 32-stage
// restoring divider that forms (bias - synaptic current - currents)/capacitance;
// twelve stages in front of it form the differences, products, sigmoid lookups with
// linear interpolation and the current sum, and one output register closes it. A
// single skid entry behind the output register lets the pipeline keep moving for one
// beat after the sink stalls; the pipeline then freezes as a whole and nothing is
// lost or repeated. The sigmoid curve is a constant table of SIGMOID_TABLE_DEPTH+1
// points over [-8, 8], held three times so each gate curve gets its own read ports.
// Configuration lives in eight 64-bit registers, written through i_cfg_we/i_cfg_idx/
// i_cfg_data, and must only be changed while the pipeline is empty.
module bursting_neuron_derivative #(
    parameter int SIGMOID_TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bnd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    bnd_chan_if.sink                       i_in,
    bnd_chan_if.source                     o_out
);
    import bnd_pkg::*;

    localparam int AW = $clog2(SIGMOID_TABLE_DEPTH + 1);
    localparam int PW = 21 + AW;
    localparam logic [AW-1:0] IDX_LAST = AW'(SIGMOID_TABLE_DEPTH);
    localparam logic [PW-1:0] DEPTH_K  = PW'(SIGMOID_TABLE_DEPTH);
    localparam logic [19:0]   ARG_LIM  = 20'h80000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KSL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KG  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CG  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CR  = 3'd7;

    // First-level product lanes: three sigmoid arguments, four current factors
    localparam int N_LANES = 7;
    localparam int N_SIG   = 3;
    localparam int N_CUR   = 4;
    localparam int LN_XK   = 0;
    localparam int LN_XS   = 1;
    localparam int LN_XC   = 2;
    localparam int LN_CA   = 3;
    localparam int LN_K    = 4;
    localparam int LN_KS   = 5;
    localparam int LN_L    = 6;
    localparam int SG_K    = 0;
    localparam int SG_S    = 1;
    localparam int SG_C    = 2;
    localparam int CI_CA   = 0;
    localparam int CI_K    = 1;
    localparam int CI_KS   = 2;
    localparam int CI_L    = 3;
    localparam int N_STG   = 12;

    typedef struct packed {
        logic        [16:0] m;
        logic        [16:0] c;
        logic signed [31:0] syn;
    } t_carry;

    // ---------------------------------------------------------------- configuration
    logic [63:0] r_cfg [0:CFG_REGS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    logic [31:0] lane_gain [0:N_LANES-1];
    logic [31:0] lane_ref  [0:N_LANES-1];
    logic [31:0] cfg_bias;
    logic [31:0] cfg_cap;
    logic [15:0] cfg_eps;
    logic [15:0] cfg_dlt;

    always_comb begin
        lane_gain[LN_XK] = r_cfg[REG_KG][63:32];
        lane_ref[LN_XK]  = r_cfg[REG_KG][31:0];
        lane_gain[LN_XS] = r_cfg[REG_SG][63:32];
        lane_ref[LN_XS]  = r_cfg[REG_SG][31:0];
        lane_gain[LN_XC] = r_cfg[REG_CG][63:32];
        lane_ref[LN_XC]  = r_cfg[REG_CG][31:0];
        lane_gain[LN_CA] = r_cfg[REG_CA][63:32];
        lane_ref[LN_CA]  = r_cfg[REG_CA][31:0];
        lane_gain[LN_K]  = r_cfg[REG_K][63:32];
        lane_ref[LN_K]   = r_cfg[REG_K][31:0];
        lane_gain[LN_KS] = r_cfg[REG_KSL][63:32];
        lane_ref[LN_KS]  = r_cfg[REG_K][31:0];
        lane_gain[LN_L]  = r_cfg[REG_KSL][31:0];
        lane_ref[LN_L]   = r_cfg[REG_LB][63:32];
    end

    assign cfg_bias = r_cfg[REG_LB][31:0];
    assign cfg_cap  = r_cfg[REG_CR][63:32];
    assign cfg_eps  = r_cfg[REG_CR][31:16];
    assign cfg_dlt  = r_cfg[REG_CR][15:0];

    // ---------------------------------------------------------------- flow control
    // The whole pipeline advances together; it only freezes while the skid holds a beat.
    logic            en;
    logic            r_ovld;
    logic            r_skid_vld;
    t_out_item       r_out;
    t_out_item       r_skid;
    logic [N_STG:1]  r_vld;

    assign en         = !r_skid_vld;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STG-1:1], i_in.valid};
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Voltage minus each reference, kept at 33 bits so nothing wraps.
    logic [32:0] r1_d [0:N_LANES-1];
    t_carry      r1_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < N_LANES; l++) begin
                r1_d[l] <= {i_in.data.membrane_voltage[31], i_in.data.membrane_voltage}
                         - {lane_ref[l][31], lane_ref[l]};
            end
            r1_cy.m   <= i_in.data.k_gate;
            r1_cy.c   <= i_in.data.slow_k_gate;
            r1_cy.syn <= i_in.data.synaptic_current;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Split every operand pair into magnitudes and a product sign.
    logic [31:0] r2_ma  [0:N_LANES-1];
    logic [32:0] r2_mb  [0:N_LANES-1];
    logic        r2_neg [0:N_LANES-1];
    t_carry      r2_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < N_LANES; l++) begin
                r2_ma[l]  <= lane_gain[l][31] ? (~lane_gain[l] + 32'd1) : lane_gain[l];
                r2_mb[l]  <= r1_d[l][32] ? (~r1_d[l] + 33'd1) : r1_d[l];
                r2_neg[l] <= lane_gain[l][31] ^ r1_d[l][32];
            end
            r2_cy <= r1_cy;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Magnitude products, dropped back to Q16.16 by truncation.
    logic [64:0] prod3 [0:N_LANES-1];
    logic [46:0] r3_p   [0:N_LANES-1];
    logic        r3_neg [0:N_LANES-1];
    t_carry      r3_cy;

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            prod3[l] = 65'(r2_ma[l]) * 65'(r2_mb[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < N_LANES; l++) begin
                r3_p[l]   <= prod3[l][62:16];
                r3_neg[l] <= r2_neg[l];
            end
            r3_cy <= r2_cy;
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Clamp each sigmoid argument to [-8, 8] and turn it into a table position.
    logic [19:0]   arg_mag [0:N_SIG-1];
    logic [20:0]   arg_off [0:N_SIG-1];
    logic [PW-1:0] arg_pos [0:N_SIG-1];
    logic [AW-1:0] r4_idx_a [0:N_SIG-1];
    logic [AW-1:0] r4_idx_b [0:N_SIG-1];
    logic [15:0]   r4_frac  [0:N_SIG-1];
    logic [46:0]   r4_cm    [0:N_CUR-1];
    logic          r4_cn    [0:N_CUR-1];
    t_carry        r4_cy;

    always_comb begin
        for (int s = 0; s < N_SIG; s++) begin
            arg_mag[s] = (r3_p[s] > 47'(ARG_LIM)) ? ARG_LIM : r3_p[s][19:0];
            arg_off[s] = r3_neg[s] ? (21'(ARG_LIM) - 21'(arg_mag[s]))
                                   : (21'(ARG_LIM) + 21'(arg_mag[s]));
            arg_pos[s] = PW'(arg_off[s]) * DEPTH_K;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < N_SIG; s++) begin
                r4_idx_a[s] <= arg_pos[s][AW+19:20];
                // The top point has no right neighbour; its fraction is always zero.
                r4_idx_b[s] <= (arg_pos[s][AW+19:20] == IDX_LAST) ? IDX_LAST
                             : arg_pos[s][AW+19:20] + AW'(1);
                r4_frac[s]  <= arg_pos[s][19:4];
            end
            for (int ci = 0; ci < N_CUR; ci++) begin
                r4_cm[ci] <= r3_p[LN_CA + ci];
                r4_cn[ci] <= r3_neg[LN_CA + ci];
            end
            r4_cy <= r3_cy;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // Table read: one copy per curve, two neighbouring points each.
    logic [16:0] rom_a [0:N_SIG-1];
    logic [16:0] rom_b [0:N_SIG-1];
    logic [15:0] r5_frac [0:N_SIG-1];
    logic [46:0] r5_cm   [0:N_CUR-1];
    logic        r5_cn   [0:N_CUR-1];
    t_carry      r5_cy;

    for (genvar s = 0; s < N_SIG; s++) begin : g_rom
        bnd_sig_rom #(
            .DEPTH    (SIGMOID_TABLE_DEPTH)
        ) u_rom (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_addr_a (r4_idx_a[s]),
            .i_addr_b (r4_idx_b[s]),
            .o_data_a (rom_a[s]),
            .o_data_b (rom_b[s])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_frac <= r4_frac;
            r5_cm   <= r4_cm;
            r5_cn   <= r4_cn;
            r5_cy   <= r4_cy;
        end
    end

    // ---------------------------------------------------------------- stage 6
    // Interpolation step, truncated towards the lower point.
    logic [16:0] step_d [0:N_SIG-1];
    logic [32:0] step_p [0:N_SIG-1];
    logic [16:0] r6_t0  [0:N_SIG-1];
    logic [16:0] r6_dl  [0:N_SIG-1];
    logic        r6_up  [0:N_SIG-1];
    logic [46:0] r6_cm  [0:N_CUR-1];
    logic        r6_cn  [0:N_CUR-1];
    t_carry      r6_cy;

    always_comb begin
        for (int s = 0; s < N_SIG; s++) begin
            step_d[s] = (rom_b[s] >= rom_a[s]) ? (rom_b[s] - rom_a[s]) : (rom_a[s] - rom_b[s]);
            step_p[s] = 33'(step_d[s]) * 33'(r5_frac[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < N_SIG; s++) begin
                r6_t0[s] <= rom_a[s];
                r6_up[s] <= rom_b[s] >= rom_a[s];
                r6_dl[s] <= step_p[s][32:16];
            end
            r6_cm <= r5_cm;
            r6_cn <= r5_cn;
            r6_cy <= r5_cy;
        end
    end

    // ---------------------------------------------------------------- stage 7
    logic [16:0] r7_cv [0:N_SIG-1];
    logic [46:0] r7_cm [0:N_CUR-1];
    logic        r7_cn [0:N_CUR-1];
    t_carry      r7_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < N_SIG; s++) begin
                r7_cv[s] <= r6_up[s] ? (r6_t0[s] + r6_dl[s]) : (r6_t0[s] - r6_dl[s]);
            end
            r7_cm <= r6_cm;
            r7_cn <= r6_cn;
            r7_cy <= r6_cy;
        end
    end

    // ---------------------------------------------------------------- stage 8
    // Second-level current products as two partial products; gate errors.
    logic [16:0] cur_f  [0:N_SIG-1];
    logic [17:0] gerr   [0:1];
    logic [17:0] gerr_m [0:1];
    logic [40:0] r8_lo  [0:N_SIG-1];
    logic [39:0] r8_hi  [0:N_SIG-1];
    logic        r8_neg [0:N_SIG-1];
    logic [46:0] r8_lm;
    logic        r8_ln;
    logic [16:0] r8_gm  [0:1];
    logic        r8_gn  [0:1];
    logic [31:0] r8_syn;

    always_comb begin
        cur_f[CI_CA] = r7_cv[SG_C];
        cur_f[CI_K]  = r7_cy.m;
        cur_f[CI_KS] = r7_cy.c;
        gerr[0]      = {1'b0, r7_cv[SG_K]} - {1'b0, r7_cy.m};
        gerr[1]      = {1'b0, r7_cv[SG_S]} - {1'b0, r7_cy.c};
        for (int g = 0; g < 2; g++) begin
            gerr_m[g] = gerr[g][17] ? (~gerr[g] + 18'd1) : gerr[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ci = 0; ci < N_SIG; ci++) begin
                r8_lo[ci]  <= 41'(r7_cm[ci][23:0]) * 41'(cur_f[ci]);
                r8_hi[ci]  <= 40'(r7_cm[ci][46:24]) * 40'(cur_f[ci]);
                r8_neg[ci] <= r7_cn[ci];
            end
            r8_lm  <= r7_cm[CI_L];
            r8_ln  <= r7_cn[CI_L];
            for (int g = 0; g < 2; g++) begin
                r8_gm[g] <= gerr_m[g][16:0];
                r8_gn[g] <= gerr[g][17];
            end
            r8_syn <= r7_cy.syn;
        end
    end

    // ---------------------------------------------------------------- stage 9
    // Merge partials, apply signs; gate rates are rate*5*error / 2^18.
    logic [63:0] cur_full [0:N_SIG-1];
    logic [18:0] rate5    [0:1];
    logic [35:0] gprod    [0:1];
    logic [49:0] r9_i     [0:N_CUR-1];
    logic [31:0] r9_gr    [0:1];
    logic [31:0] r9_syn;

    always_comb begin
        for (int ci = 0; ci < N_SIG; ci++) begin
            cur_full[ci] = {r8_hi[ci], 24'd0} + 64'(r8_lo[ci]);
        end
        rate5[0] = (19'(cfg_eps) << 2) + 19'(cfg_eps);
        rate5[1] = (19'(cfg_dlt) << 2) + 19'(cfg_dlt);
        for (int g = 0; g < 2; g++) begin
            gprod[g] = 36'(rate5[g]) * 36'(r8_gm[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ci = 0; ci < N_SIG; ci++) begin
                r9_i[ci] <= r8_neg[ci] ? (~50'(cur_full[ci][63:16]) + 50'd1)
                                       : 50'(cur_full[ci][63:16]);
            end
            r9_i[CI_L] <= r8_ln ? (~50'(r8_lm) + 50'd1) : 50'(r8_lm);
            for (int g = 0; g < 2; g++) begin
                r9_gr[g] <= r8_gn[g] ? (~32'(gprod[g][35:18]) + 32'd1) : 32'(gprod[g][35:18]);
            end
            r9_syn <= r8_syn;
        end
    end

    // ---------------------------------------------------------------- stage 10
    logic [50:0] r10_s1;
    logic [50:0] r10_s2;
    logic [32:0] r10_s3;
    logic [31:0] r10_gr [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_s1 <= {r9_i[CI_CA][49], r9_i[CI_CA]} + {r9_i[CI_K][49], r9_i[CI_K]};
            r10_s2 <= {r9_i[CI_KS][49], r9_i[CI_KS]} + {r9_i[CI_L][49], r9_i[CI_L]};
            r10_s3 <= {cfg_bias[31], cfg_bias} - {r9_syn[31], r9_syn};
            r10_gr <= r9_gr;
        end
    end

    // ---------------------------------------------------------------- stage 11
    logic [52:0] r11_num;
    logic [31:0] r11_gr [0:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_num <= {{20{r10_s3[32]}}, r10_s3} - {{2{r10_s1[50]}}, r10_s1}
                     - {{2{r10_s2[50]}}, r10_s2};
            r11_gr  <= r10_gr;
        end
    end

    // ---------------------------------------------------------------- stage 12
    // Numerator magnitude and the quotient-overflow test ahead of the divider.
    logic [52:0] num_mag;
    logic [31:0] r12_rem;
    logic [31:0] r12_low;
    t_div_side   r12_side;

    assign num_mag = r11_num[52] ? (~r11_num + 53'd1) : r11_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_rem         <= {1'b0, num_mag[46:16]};
            r12_low         <= {num_mag[15:0], 16'd0};
            r12_side.neg    <= r11_num[52];
            r12_side.zero   <= r11_num == 53'd0;
            // Quotient of 2^32 or more, zero capacitance included, or a huge numerator
            r12_side.sat    <= (|num_mag[52:47]) || ({1'b0, num_mag[46:16]} >= cfg_cap);
            r12_side.k_rate <= r11_gr[0];
            r12_side.s_rate <= r11_gr[1];
        end
    end

    // ---------------------------------------------------------------- divider
    logic        div_vld;
    logic [31:0] div_q;
    t_div_side   div_side;

    bnd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[N_STG]),
        .i_rem   (r12_rem),
        .i_low   (r12_low),
        .i_den   (cfg_cap),
        .i_side  (r12_side),
        .o_vld   (div_vld),
        .o_quot  (div_q),
        .o_side  (div_side)
    );

    // ---------------------------------------------------------------- result
    t_out_item res;

    always_comb begin
        res.k_gate_rate      = div_side.k_rate;
        res.slow_k_gate_rate = div_side.s_rate;
        if (div_side.zero) begin
            res.voltage_rate = 32'sd0;
        end else if (div_side.sat) begin
            res.voltage_rate = div_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!div_side.neg) begin
            res.voltage_rate = div_q[31] ? 32'h7FFF_FFFF : div_q;
        end else begin
            res.voltage_rate = (div_q > 32'h8000_0000) ? 32'h8000_0000 : (~div_q + 32'd1);
        end
    end

    // Output register plus one skid entry: take a beat into the skid when the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld     <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (o_out.ready || !r_ovld) begin
            if (r_skid_vld) begin
                r_ovld     <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_ovld <= div_vld;
            end
        end else if (en && div_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out.ready || !r_ovld) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (en && div_vld) begin
            r_skid <= res;
        end
    end

    assign o_out.valid = r_ovld;
    assign o_out.data  = r_out;

    // ---------------------------------------------------------------- checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_ovld)
        else $error("skid entry held without a valid output beat");

    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(div_vld) && $stable(div_q))
        else $error("divider moved while the pipeline was frozen");

    a_gate_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> ($signed(r_out.k_gate_rate) <= 32'sd262144
                 && $signed(r_out.k_gate_rate) >= -32'sd262144
                 && $signed(r_out.slow_k_gate_rate) <= 32'sd262144
                 && $signed(r_out.slow_k_gate_rate) >= -32'sd262144))
        else $error("gate rate outside the reachable range");
endmodule

// ===== sv/bnd_sig_rom.sv =====
module bnd_sig_rom #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr_a,
    input  logic [AW-1:0] i_addr_b,
    output logic [16:0]   o_data_a,
    output logic [16:0]   o_data_b
);
    import bnd_pkg::*;

    typedef logic [16:0] t_rom [0:DEPTH];

    // Sample points run from -8 to +8; the negative half mirrors the positive one
    function automatic t_rom build_rom();
        t_rom    rom;
        longint  x;
        for (int i = 0; i <= DEPTH; i++) begin
            x = (longint'(i) * 64'sd1048576) / DEPTH - 64'sd524288;
            if (x >= 0) begin
                rom[i] = logistic_pos(x);
            end else begin
                rom[i] = 17'd65536 - logistic_pos(-x);
            end
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [16:0] r_data_a;
    logic [16:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= ROM[i_addr_a];
            r_data_b <= ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;
endmodule

// ===== sv/bnd_div.sv =====
module bnd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [31:0]         i_rem,
    input  logic [31:0]         i_low,
    input  logic [31:0]         i_den,
    input  bnd_pkg::t_div_side  i_side,
    output logic                o_vld,
    output logic [31:0]         o_quot,
    output bnd_pkg::t_div_side  o_side
);
    import bnd_pkg::*;

    // One restoring step per stage, most significant quotient bit first
    logic      [DIV_STEPS-1:0] r_vld;
    logic      [31:0]          r_rem  [0:DIV_STEPS-1];
    logic      [31:0]          r_low  [0:DIV_STEPS-1];
    logic      [31:0]          r_quot [0:DIV_STEPS-1];
    t_div_side                 r_side [0:DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic      vld_in;
        logic      [31:0] rem_in;
        logic      [31:0] low_in;
        logic      [31:0] quot_in;
        t_div_side side_in;
        logic      [32:0] trial;
        logic      [32:0] diff;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = i_rem;
            assign low_in  = i_low;
            assign quot_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quot_in = r_quot[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = {rem_in, low_in[31]};
        assign diff  = trial - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!diff[32]) begin
                    r_rem[k]  <= diff[31:0];
                    r_quot[k] <= {quot_in[30:0], 1'b1};
                end else begin
                    r_rem[k]  <= trial[31:0];
                    r_quot[k] <= {quot_in[30:0], 1'b0};
                end
                r_low[k]  <= {low_in[30:0], 1'b0};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_quot = r_quot[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];
endmodule

// ===== tb/bursting_neuron_derivative_tb.sv =====
`timescale 1ns / 1ps

// Scoreboard: a bit-exact predictor of the three rates, plus a queue of the
// rates that are still owed by the block.
class derivative_scoreboard;
    localparam int DEPTH   = 1024;
    localparam longint LIM = 8 * 65536;

    logic [63:0]         cfg_regs [8];
    longint unsigned     curve_tab [DEPTH + 1];
    bnd_pkg::t_out_item  owed_rates [$];
    int                  errors;
    int                  checked;

    function new();
        longint x;
        for (int i = 0; i < 8; i++) cfg_regs[i] = '0;
        for (int i = 0; i <= DEPTH; i++) begin
            x = longint'(i) * 16 * 65536 / DEPTH - LIM;
            if (x >= 0) curve_tab[i] = half_logistic(x);
            else curve_tab[i] = 65536 - half_logistic(-x);
        end
        errors  = 0;
        checked = 0;
    endfunction

    // 1/(1+exp(-a)) for a >= 0: series for exp(-a/8), then square three times
    function longint unsigned half_logistic(longint unsigned a);
        longint unsigned y, term, e, den;
        longint acc;
        y    = a << 11;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * y) >> 30) / k;
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        e = longint'(acc);
        for (int k = 0; k < 3; k++) e = (e * e) >> 30;
        den = (64'd1 << 30) + e;
        return ((64'd1 << 46) + den / 2) / den;
    endfunction

    function longint word(logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    // exact product, magnitude truncated by sh bits
    function longint mul_trunc(longint a, longint b, int sh);
        longint unsigned ma, mb, p;
        ma = a < 0 ? longint'(-a) : a;
        mb = b < 0 ? longint'(-b) : b;
        p  = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function longint gate_curve(logic [63:0] r, longint v);
        longint x;
        longint unsigned pos, idx, frac, t0, t1;
        x = mul_trunc(word(r[63:32]), v - word(r[31:0]), 16);
        if (x > LIM) x = LIM;
        if (x < -LIM) x = -LIM;
        pos  = (longint'(x + LIM) * DEPTH) >> 4;
        idx  = pos >> 16;
        frac = pos & 64'hFFFF;
        if (idx >= DEPTH) return curve_tab[DEPTH];
        t0 = curve_tab[idx];
        t1 = curve_tab[idx + 1];
        if (t1 >= t0) return t0 + (((t1 - t0) * frac) >> 16);
        return t0 - (((t0 - t1) * frac) >> 16);
    endfunction

    function longint over_capacitance(longint num, longint unsigned cap);
        longint unsigned mag, q;
        mag = num < 0 ? longint'(-num) : num;
        if (num == 0) return 0;
        if (cap == 0 || mag >= (64'd1 << 47)) return num < 0 ? -64'sd2147483648 : 64'sd2147483647;
        q = (mag << 16) / cap;
        if (q > (64'd1 << 32)) q = 64'd1 << 32;
        return clip32(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    function bnd_pkg::t_out_item predict_rates(bnd_pkg::t_in_item it);
        bnd_pkg::t_out_item r;
        longint v, m, c, ek, m_inf, c_inf, n_inf, ica, ik, iks, il, num, eps, dlt;
        v     = word(it.membrane_voltage);
        m     = it.k_gate;
        c     = it.slow_k_gate;
        ek    = word(cfg_regs[1][31:0]);
        eps   = cfg_regs[7][31:16];
        dlt   = cfg_regs[7][15:0];
        m_inf = gate_curve(cfg_regs[4], v);
        c_inf = gate_curve(cfg_regs[5], v);
        n_inf = gate_curve(cfg_regs[6], v);
        ica = mul_trunc(mul_trunc(word(cfg_regs[0][63:32]), v - word(cfg_regs[0][31:0]), 16),
                        n_inf, 16);
        ik  = mul_trunc(mul_trunc(word(cfg_regs[1][63:32]), v - ek, 16), m, 16);
        iks = mul_trunc(mul_trunc(word(cfg_regs[2][63:32]), v - ek, 16), c, 16);
        il  = mul_trunc(word(cfg_regs[2][31:0]), v - word(cfg_regs[3][63:32]), 16);
        num = word(cfg_regs[3][31:0]) - word(it.synaptic_current) - (ica + ik + iks + il);
        r.voltage_rate     = 32'(over_capacitance(num, cfg_regs[7][63:32]));
        r.k_gate_rate      = 32'(clip32(mul_trunc(eps * 5, m_inf - m, 18)));
        r.slow_k_gate_rate = 32'(clip32(mul_trunc(dlt * 5, c_inf - c, 18)));
        return r;
    endfunction

    function void note_state(bnd_pkg::t_in_item it);
        owed_rates.push_back(predict_rates(it));
    endfunction

    function void check_rates(bnd_pkg::t_out_item got);
        bnd_pkg::t_out_item exp_r;
        checked++;
        if (owed_rates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %h", $realtime, got);
            return;
        end
        exp_r = owed_rates.pop_front();
        if (got.voltage_rate !== exp_r.voltage_rate) begin
            errors++;
            $display("%0t: voltage_rate expected %0d got %0d", $realtime,
                     exp_r.voltage_rate, got.voltage_rate);
        end
        if (got.k_gate_rate !== exp_r.k_gate_rate) begin
            errors++;
            $display("%0t: k_gate_rate expected %0d got %0d", $realtime,
                     exp_r.k_gate_rate, got.k_gate_rate);
        end
        if (got.slow_k_gate_rate !== exp_r.slow_k_gate_rate) begin
            errors++;
            $display("%0t: slow_k_gate_rate expected %0d got %0d", $realtime,
                     exp_r.slow_k_gate_rate, got.slow_k_gate_rate);
        end
    endfunction
endclass

module bursting_neuron_derivative_tb;
    import bnd_pkg::*;

    localparam int  LATENCY     = 45;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  Q1          = 65536;
    localparam int  IN_W        = $bits(t_in_item);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CA, REG_K, REG_KS_LEAK, REG_EL_BIAS,
        REG_K_GATE, REG_SLOW_GATE, REG_CA_GATE, REG_CAP_RATES
    } t_reg_idx;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    bnd_chan_if #(.t_data(t_in_item))  in_ch ();
    bnd_chan_if #(.t_data(t_out_item)) out_ch ();

    bursting_neuron_derivative dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    derivative_scoreboard sb = new();

    int  cycles = 0;
    int  sent;
    bit  calm;              // suppress idling on both sides
    int  hold_asked;        // hold-off requests raised by the stimulus
    int  hold_done;
    int  hold_left;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycles, sb.owed_rates.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: stall at random, and hold off for a long stretch on request
    initial begin
        out_ch.ready = 1'b0;
        hold_done = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_done != hold_asked) begin
                hold_done = hold_asked;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = calm || ($urandom_range(99) >= 32);
            end
        end
    end

    // check every result beat at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_rates(out_ch.data);
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.cfg_regs[idx] = val;
    endtask

    // offer one beat, idling first at random; return once it is taken
    task automatic send_state(t_in_item it);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 32) begin
            in_ch.valid = 1'b0;
            in_ch.data  = IN_W'({$urandom, $urandom, $urandom, $urandom});
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_state(it);
        sent++;
    endtask

    // drop valid and let the pipeline drain completely
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.owed_rates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] span(int r);
        return $urandom_range(0, 2 * r) - r;
    endfunction

    // Plausible neuron constants: modest conductances, reversals within
    // about a hundred volts, slopes that actually sweep the curve.
    task automatic load_plausible();
        write_reg(REG_CA,        {32'($urandom_range(0, 10 * Q1)), span(100 * Q1)});
        write_reg(REG_K,         {32'($urandom_range(0, 10 * Q1)), span(100 * Q1)});
        write_reg(REG_KS_LEAK,   {32'($urandom_range(0, 5 * Q1)), 32'($urandom_range(0, 2 * Q1))});
        write_reg(REG_EL_BIAS,   {span(100 * Q1), span(50 * Q1)});
        write_reg(REG_K_GATE,    {span(Q1), span(50 * Q1)});
        write_reg(REG_SLOW_GATE, {span(Q1), span(50 * Q1)});
        write_reg(REG_CA_GATE,   {span(Q1), span(50 * Q1)});
        write_reg(REG_CAP_RATES, {32'($urandom_range(Q1 / 8, 4 * Q1)), 32'($urandom)});
    endtask

    task automatic load_all(logic [63:0] val);
        for (int i = 0; i < CFG_REGS; i++) write_reg(t_reg_idx'(i), val);
    endtask

    function automatic t_in_item make_state(bit wild);
        t_in_item it;
        if (wild) begin
            it.membrane_voltage = $urandom;
            it.k_gate           = 17'($urandom_range(0, 131071));
            it.slow_k_gate      = 17'($urandom_range(0, 131071));
            it.synaptic_current = $urandom;
        end else begin
            it.membrane_voltage = span(100 * Q1);
            it.k_gate           = 17'($urandom_range(0, Q1));
            it.slow_k_gate      = 17'($urandom_range(0, Q1));
            it.synaptic_current = span(20 * Q1);
        end
        return it;
    endfunction

    function automatic t_in_item corner(logic [31:0] v, logic [16:0] m, logic [16:0] c,
                                       logic [31:0] syn);
        t_in_item it;
        it.membrane_voltage = v;
        it.k_gate           = m;
        it.slow_k_gate      = c;
        it.synaptic_current = syn;
        return it;
    endfunction

    task automatic run_corners();
        send_state(corner(32'h0, 17'd0, 17'd0, 32'h0));
        send_state(corner(32'h7FFFFFFF, 17'd65536, 17'd131071, 32'h80000000));
        send_state(corner(32'h80000000, 17'd131071, 17'd65536, 32'h7FFFFFFF));
        send_state(corner(32'hFFFFFFFF, 17'd1, 17'd131071, 32'hFFFFFFFF));
        send_state(corner(32'h00010000, 17'd65535, 17'd0, 32'h00000001));
        send_state(corner(32'hFFF00000, 17'd0, 17'd65536, 32'h00000000));
    endtask

    initial begin
        int phase_items;
        sent           = 0;
        calm           = 1'b0;
        hold_asked     = 0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset values first (zero capacitance, so the voltage rate
        // saturates by the sign of the numerator or is zero), then a plausible
        // set with huge synaptic drive, then two extreme sets.
        run_corners();
        drain();
        load_plausible();
        run_corners();
        send_state(corner(32'h00320000, 17'd32768, 17'd32768, 32'h80000000));
        send_state(corner(32'hFFCE0000, 17'd32768, 17'd32768, 32'h7FFFFFFF));
        drain();
        load_all(64'hFFFFFFFF_FFFFFFFF);
        run_corners();
        drain();
        load_all(64'h7FFFFFFF_80000000);
        run_corners();
        drain();

        // Random phases; each rewrites every register while the block is empty.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 5)
                1:       load_all({$urandom, $urandom});
                3:       load_all(64'h80000000_7FFFFFFF);
                default: load_plausible();
            endcase
            calm = (ph == 2);
            if (ph == 4) hold_asked++;
            phase_items = 100;
            for (int n = 0; n < phase_items; n++) send_state(make_state($urandom_range(3) == 0));
            // pause until every owed result is back
            drain();
        end
        calm = 1'b0;

        $display("%0d state vectors sent, %0d result beats checked over 13 configurations",
                 sent, sb.checked);
        $display("random stalls on both sides, one unstalled phase, one 300-cycle receiver hold");
        if (sb.errors == 0 && sb.owed_rates.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.owed_rates.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/bnd_pkg.sv
sv/bnd_chan_if.sv
sv/bnd_sig_rom.sv
sv/bnd_div.sv
sv/bursting_neuron_derivative.sv
tb/bursting_neuron_derivative_tb.sv
